@@ src/weighted_union_find_unit_defines.svh @@
// Assertion macros shared by the weighted union-find RTL.
`ifndef WEIGHTED_UNION_FIND_UNIT_DEFINES_SVH
`define WEIGHTED_UNION_FIND_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define WUF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("weighted union-find assertion failed");

// Next-cycle implication.
`define WUF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("weighted union-find assertion failed");

`else

`define WUF_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define WUF_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ src/wuf_pkg.sv @@
package wuf_pkg;

  localparam int NODES_DEF = 1024;
  localparam int FIELD_W   = 10;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK_A,
    ST_WALK_B,
    ST_SIZE_B,
    ST_LINK
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic clear;    // write one reset entry, advance sweep counter
    logic load;     // take the item, start walk from first node
    logic step;     // follow one parent link
    logic to_b;     // latch first root, start walk from second node
    logic size_ra;  // read size of first root
    logic size_rb;  // latch first size, read size of second root
    logic link;     // hang smaller tree, update size, emit item
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic clr_last;
    logic in_range;
    logic at_root;
    logic same_root;
    logic out_free;
  } sts_t;

endpackage

@@ src/wuf_ctrl.sv @@
`include "weighted_union_find_unit_defines.svh"

module wuf_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  wuf_pkg::sts_t sts,
  output wuf_pkg::cmd_t cmd
);
  import wuf_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        // drop an item whose indices fall outside the tables
        if (in_valid && sts.in_range) begin
          cmd.load  = 1'b1;
          state_nxt = ST_WALK_A;
        end
      end
      ST_WALK_A: begin
        if (sts.at_root) begin
          cmd.to_b  = 1'b1;
          state_nxt = ST_WALK_B;
        end else begin
          cmd.step = 1'b1;
        end
      end
      ST_WALK_B: begin
        if (sts.at_root) begin
          if (sts.same_root) begin
            state_nxt = ST_IDLE;
          end else begin
            cmd.size_ra = 1'b1;
            state_nxt   = ST_SIZE_B;
          end
        end else begin
          cmd.step = 1'b1;
        end
      end
      ST_SIZE_B: begin
        cmd.size_rb = 1'b1;
        state_nxt   = ST_LINK;
      end
      ST_LINK: begin
        // hold until the output register can take the item
        if (sts.out_free) begin
          cmd.link  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  `WUF_ASSERT_IMP(a_link_needs_room, clk, rst_n, cmd.link, sts.out_free)

endmodule

@@ src/wuf_dp.sv @@
`include "weighted_union_find_unit_defines.svh"

module wuf_dp #(
  parameter int NODES = wuf_pkg::NODES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [wuf_pkg::FIELD_W-1:0] in_first_node,
  input  logic [wuf_pkg::FIELD_W-1:0] in_second_node,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [wuf_pkg::FIELD_W-1:0] out_joined_first,
  output logic [wuf_pkg::FIELD_W-1:0] out_joined_second,
  input  wuf_pkg::cmd_t               cmd,
  output wuf_pkg::sts_t               sts
);
  import wuf_pkg::*;

  localparam int NW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int SW = NW + 1;

  logic [NW-1:0] parent_mem [NODES];
  logic [SW-1:0] size_mem   [NODES];

  logic [NW-1:0]      clr_r;
  logic [FIELD_W-1:0] a_r, b_r;
  logic [NW-1:0]      cur_r, ra_r;
  logic [NW-1:0]      prd_r;
  logic [SW-1:0]      srd_r, sa_r;
  logic               out_valid_r;
  logic [FIELD_W-1:0] out_first_r, out_second_r;

  logic [31:0]   a_in_ext, b_in_ext, b_r_ext;
  logic [NW-1:0] a_in_idx, b_idx;
  logic          a_small;
  logic [SW-1:0] size_sum;

  logic          p_re, p_we, s_re, s_we;
  logic [NW-1:0] p_raddr, p_waddr, p_wdata, s_raddr, s_waddr;
  logic [SW-1:0] s_wdata;

  assign a_in_ext = 32'(in_first_node);
  assign b_in_ext = 32'(in_second_node);
  assign b_r_ext  = 32'(b_r);
  assign a_in_idx = a_in_ext[NW-1:0];
  assign b_idx    = b_r_ext[NW-1:0];

  assign a_small  = sa_r < srd_r;
  assign size_sum = sa_r + srd_r;

  // parent table ports
  assign p_re    = cmd.load | cmd.step | cmd.to_b;
  assign p_raddr = cmd.load ? a_in_idx : (cmd.to_b ? b_idx : prd_r);
  assign p_we    = cmd.clear | cmd.link;
  assign p_waddr = cmd.clear ? clr_r : (a_small ? ra_r : cur_r);
  assign p_wdata = cmd.clear ? clr_r : (a_small ? cur_r : ra_r);

  // size table ports
  assign s_re    = cmd.size_ra | cmd.size_rb;
  assign s_raddr = cmd.size_ra ? ra_r : cur_r;
  assign s_we    = cmd.clear | cmd.link;
  assign s_waddr = cmd.clear ? clr_r : (a_small ? cur_r : ra_r);
  assign s_wdata = cmd.clear ? SW'(1) : size_sum;

  always_ff @(posedge clk) begin
    if (p_we) begin
      parent_mem[p_waddr] <= p_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (p_re) begin
      prd_r <= parent_mem[p_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (s_we) begin
      size_mem[s_waddr] <= s_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (s_re) begin
      srd_r <= size_mem[s_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (cmd.clear) begin
      clr_r <= clr_r + NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a_r   <= in_first_node;
      b_r   <= in_second_node;
      cur_r <= a_in_idx;
    end else if (cmd.to_b) begin
      ra_r  <= cur_r;
      cur_r <= b_idx;
    end else if (cmd.step) begin
      cur_r <= prd_r;
    end
    if (cmd.size_rb) begin
      sa_r <= srd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.link) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.link) begin
      out_first_r  <= a_r;
      out_second_r <= b_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_joined_first  = out_first_r;
  assign out_joined_second = out_second_r;

  assign sts.clr_last  = clr_r == NW'(NODES - 1);
  assign sts.in_range  = (a_in_ext < 32'(NODES)) && (b_in_ext < 32'(NODES));
  assign sts.at_root   = prd_r == cur_r;
  assign sts.same_root = cur_r == ra_r;
  assign sts.out_free  = !out_valid_r || !out_stall;

  `WUF_ASSERT_IMP(a_link_roots_differ, clk, rst_n, cmd.link, ra_r != cur_r)
  `WUF_ASSERT_NXT(a_link_emits, clk, rst_n, cmd.link, out_valid_r)

endmodule

@@ src/weighted_union_find_unit.sv @@
// Search: each item walks from its first node and then from its second node up to the root;
//   each walk follows one parent link per cycle from the registered table read. The sizes
//   of both roots are then read, and the smaller tree is hung under the other root.
// Input: a new item is accepted only in idle, after the block has finished with the last one.
// Items whose nodes already share a root give no result and free the block sooner.
// Reset: synchronous, active low; a clearing pass rebuilds both tables before the
//   first item is accepted.
module weighted_union_find_unit #(
  parameter int NODES = wuf_pkg::NODES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [wuf_pkg::FIELD_W-1:0] in_first_node,
  input  logic [wuf_pkg::FIELD_W-1:0] in_second_node,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [wuf_pkg::FIELD_W-1:0] out_joined_first,
  output logic [wuf_pkg::FIELD_W-1:0] out_joined_second
);
  import wuf_pkg::*;

  cmd_t cmd;
  sts_t sts;

  wuf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  wuf_dp #(
    .NODES (NODES)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_first_node     (in_first_node),
    .in_second_node    (in_second_node),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_joined_first  (out_joined_first),
    .out_joined_second (out_joined_second),
    .cmd               (cmd),
    .sts               (sts)
  );

endmodule
